[hdl/rxs_pkg.sv]
`default_nettype none

package rxs_pkg;

  // Chain geometry.
  localparam int MAX_CHAIN = 16;
  localparam int POS_W     = $clog2(MAX_CHAIN);
  localparam int LEN_W     = $clog2(MAX_CHAIN + 1);
  localparam int CFG_W     = 5;

  // Field widths.
  localparam int WEIGHT_W = 16;
  localparam int RAND_W   = 16;
  localparam int MAG_W    = WEIGHT_W + 1;
  localparam int SUM_W    = 32;
  localparam int COUNT_W  = 32;
  localparam int PROB_W   = 17;

  localparam logic [PROB_W-1:0]  PROB_ONE  = PROB_W'(65536);
  localparam logic [SUM_W-1:0]   SUM_MAX   = '1;
  localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

  // Rejection sums exist for every position that starts a pair.
  localparam int REJ_DEPTH = MAX_CHAIN - 1;
  localparam int REJ_AW    = (REJ_DEPTH > 1) ? $clog2(REJ_DEPTH) : 1;

  // Acceptance table, split into banks of at most 256 entries.
  localparam int EXP_TABLE_DEPTH = 1024;
  localparam int EXP_IDX_W  = $clog2(EXP_TABLE_DEPTH);
  localparam int EXP_SHIFT  = 12 - EXP_IDX_W;
  localparam int EXP_BANK   = (EXP_TABLE_DEPTH < 256) ? EXP_TABLE_DEPTH : 256;
  localparam int EXP_BANK_W = $clog2(EXP_BANK);
  localparam int EXP_BANKS  = EXP_TABLE_DEPTH / EXP_BANK;
  localparam int EXP_SEL_W  = (EXP_BANKS > 1) ? $clog2(EXP_BANKS) : 1;

  typedef struct packed {
    logic [LEN_W-1:0] chain_len;
    logic             load_we;
    logic [POS_W-1:0] load_addr;
    logic             perm_init;
    logic             partner_init;
    logic             ent_rd;
    logic [POS_W-1:0] ent_addr;
    logic             cap_w0;
    logic             cap_prob;
    logic             cap_look;
    logic             decide;
    logic [POS_W-1:0] pair;
    logic             rej_rd;
    logic [POS_W-1:0] rej_addr;
    logic             bump;
    logic             parity;
    logic             out_load;
    logic [POS_W-1:0] out_rank;
    logic             out_last;
  } rxs_cmd_t;

  typedef struct packed {
    logic out_free;
  } rxs_stat_t;

  // Table entry k approximates exp(-16k/EXP_TABLE_DEPTH) with 65536 as 1.0.
  // Evaluated at elaboration only.
  function automatic logic [PROB_W-1:0] exp_entry(input int unsigned k);
    logic [63:0] y;
    logic [63:0] acc;
    logic [63:0] term;
    logic [63:0] prod;
    int unsigned n;
    y    = (64'(k) << 27) >> EXP_IDX_W;
    acc  = 64'd1 << 31;
    term = 64'd1 << 31;
    for (n = 1; n <= 6; n++) begin
      prod = (term * y) >> 31;
      case (n)
        1:       term = prod;
        2:       term = prod >> 1;
        3:       term = prod / 3;
        4:       term = prod >> 2;
        5:       term = prod / 5;
        default: term = prod / 6;
      endcase
      if (n[0]) begin
        acc = acc - term;
      end else begin
        acc = acc + term;
      end
    end
    for (n = 0; n < 8; n++) begin
      acc = (acc * acc + (64'd1 << 30)) >> 31;
    end
    return PROB_W'((acc + (64'd1 << 14)) >> 15);
  endfunction

  function automatic logic [LEN_W-1:0] clamp_len(input logic [CFG_W-1:0] v);
    int unsigned x;
    x = 32'(v);
    if (x < 2) begin
      x = 2;
    end
    if (x > MAX_CHAIN) begin
      x = MAX_CHAIN;
    end
    return LEN_W'(x);
  endfunction

endpackage

`default_nettype wire

[hdl/rxs_if.sv]
`default_nettype none

interface rxs_sample_if import rxs_pkg::*; ();
  logic                       valid;
  logic                       ready;
  logic signed [WEIGHT_W-1:0] log_weight_ratio;
  logic        [RAND_W-1:0]   uniform_random;

  modport source (output valid, log_weight_ratio, uniform_random, input ready);
  modport sink   (input valid, log_weight_ratio, uniform_random, output ready);
endinterface

interface rxs_result_if import rxs_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [POS_W-1:0]   rank_index;
  logic [POS_W-1:0]   new_position;
  logic [POS_W-1:0]   swap_mate;
  logic [SUM_W-1:0]   pair_rejection_sum;
  logic [COUNT_W-1:0] parity_event_count;
  logic               last_of_event;

  modport source (output valid, rank_index, new_position, swap_mate,
                  pair_rejection_sum, parity_event_count, last_of_event,
                  input ready);
  modport sink   (input valid, rank_index, new_position, swap_mate,
                  pair_rejection_sum, parity_event_count, last_of_event,
                  output ready);
endinterface

`default_nettype wire

[hdl/rxs_ram.sv]
`default_nettype none

module rxs_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

[hdl/rxs_ctrl.sv]
`default_nettype none

module rxs_ctrl import rxs_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             cfg_we,
  input  logic [CFG_W-1:0] cfg_data,
  input  logic             in_valid,
  output logic             in_ready,
  input  rxs_stat_t        stat,
  output rxs_cmd_t         cmd
);

  typedef enum logic [8:0] {
    S_LOAD = 9'b000000001,
    S_RD0  = 9'b000000010,
    S_RD1  = 9'b000000100,
    S_PROB = 9'b000001000,
    S_LOOK = 9'b000010000,
    S_DEC  = 9'b000100000,
    S_END  = 9'b001000000,
    S_ORD  = 9'b010000000,
    S_OPUT = 9'b100000000
  } state_t;

  state_t           state, state_next;
  logic [LEN_W-1:0] chain_len;
  logic [LEN_W-1:0] load_idx, load_idx_next;
  logic [POS_W-1:0] pair, pair_next;
  logic [POS_W-1:0] rank, rank_next;
  logic             odd_phase, odd_phase_next;
  logic             in_xfer;
  logic             rank_last;

  assign in_ready  = (state == S_LOAD);
  assign in_xfer   = in_valid && in_ready;
  assign rank_last = (LEN_W'(rank) + LEN_W'(1) == chain_len);

  always_comb begin
    state_next     = state;
    load_idx_next  = load_idx;
    pair_next      = pair;
    rank_next      = rank;
    odd_phase_next = odd_phase;

    cmd           = '0;
    cmd.chain_len = chain_len;
    cmd.load_addr = POS_W'(load_idx);
    cmd.perm_init = cfg_we;
    cmd.ent_addr  = pair;
    cmd.pair      = pair;
    cmd.rej_addr  = pair;
    cmd.parity    = odd_phase;
    cmd.out_rank  = rank;
    cmd.out_last  = rank_last;

    unique case (state)
      S_LOAD: begin
        if (in_xfer) begin
          cmd.load_we = 1'b1;
          if (load_idx + LEN_W'(1) >= chain_len) begin
            load_idx_next    = '0;
            cmd.partner_init = 1'b1;
            pair_next        = POS_W'(odd_phase);
            if (LEN_W'(odd_phase) + LEN_W'(1) < chain_len) begin
              state_next = S_RD0;
            end else begin
              state_next = S_END;
            end
          end else begin
            load_idx_next = load_idx + LEN_W'(1);
          end
        end
      end
      S_RD0: begin
        cmd.ent_rd = 1'b1;
        cmd.rej_rd = 1'b1;
        state_next = S_RD1;
      end
      S_RD1: begin
        cmd.ent_rd   = 1'b1;
        cmd.ent_addr = pair + POS_W'(1);
        cmd.cap_w0   = 1'b1;
        state_next   = S_PROB;
      end
      S_PROB: begin
        cmd.cap_prob = 1'b1;
        state_next   = S_LOOK;
      end
      S_LOOK: begin
        cmd.cap_look = 1'b1;
        state_next   = S_DEC;
      end
      S_DEC: begin
        cmd.decide = 1'b1;
        if (LEN_W'(pair) + LEN_W'(3) < chain_len) begin
          pair_next  = pair + POS_W'(2);
          state_next = S_RD0;
        end else begin
          state_next = S_END;
        end
      end
      S_END: begin
        cmd.bump       = 1'b1;
        odd_phase_next = !odd_phase;
        rank_next      = '0;
        state_next     = S_ORD;
      end
      S_ORD: begin
        cmd.rej_rd   = 1'b1;
        cmd.rej_addr = rank;
        state_next   = S_OPUT;
      end
      S_OPUT: begin
        if (stat.out_free) begin
          cmd.out_load = 1'b1;
          if (rank_last) begin
            state_next = S_LOAD;
          end else begin
            rank_next  = rank + POS_W'(1);
            state_next = S_ORD;
          end
        end
      end
      default: begin
        state_next = S_LOAD;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_LOAD;
      chain_len <= clamp_len(CFG_W'(16));
      load_idx  <= '0;
      pair      <= '0;
      rank      <= '0;
      odd_phase <= 1'b0;
    end else begin
      state     <= state_next;
      pair      <= pair_next;
      rank      <= rank_next;
      odd_phase <= odd_phase_next;
      if (cfg_we) begin
        chain_len <= clamp_len(cfg_data);
        load_idx  <= '0;
      end else begin
        load_idx  <= load_idx_next;
      end
    end
  end

endmodule

`default_nettype wire

[hdl/rxs_dp.sv]
`default_nettype none

module rxs_dp import rxs_pkg::*; (
  input  logic                       clk,
  input  logic                       rst,
  input  rxs_cmd_t                   cmd,
  input  logic signed [WEIGHT_W-1:0] log_weight_ratio,
  input  logic        [RAND_W-1:0]   uniform_random,
  output rxs_stat_t                  stat,
  rxs_result_if.source               result
);

  localparam int ENT_W = WEIGHT_W + RAND_W;

  // Acceptance table as constant banks.
  logic [PROB_W-1:0] exp_rom [EXP_BANKS][EXP_BANK];

  for (genvar b = 0; b < EXP_BANKS; b++) begin : g_bank
    for (genvar e = 0; e < EXP_BANK; e++) begin : g_entry
      localparam logic [PROB_W-1:0] ENTRY = exp_entry(b * EXP_BANK + e);
      assign exp_rom[b][e] = ENTRY;
    end
  end

  // Loaded weights and random fractions, one entry per position.
  logic [ENT_W-1:0] ent_q;

  rxs_ram #(.WIDTH(ENT_W), .DEPTH(MAX_CHAIN)) u_ent_ram (
    .clk   (clk),
    .we    (cmd.load_we),
    .waddr (cmd.load_addr),
    .wdata ({log_weight_ratio, uniform_random}),
    .re    (cmd.ent_rd),
    .raddr (cmd.ent_addr),
    .rdata (ent_q)
  );

  // Rejection sums with one valid bit per entry.
  logic [SUM_W-1:0]     rej_q;
  logic [SUM_W-1:0]     rej_new;
  logic [REJ_DEPTH-1:0] rej_valid;
  logic                 rej_valid_q;

  rxs_ram #(.WIDTH(SUM_W), .DEPTH(REJ_DEPTH)) u_rej_ram (
    .clk   (clk),
    .we    (cmd.decide),
    .waddr (REJ_AW'(cmd.pair)),
    .wdata (rej_new),
    .re    (cmd.rej_rd),
    .raddr (REJ_AW'(cmd.rej_addr)),
    .rdata (rej_q)
  );

  logic [WEIGHT_W-1:0] w0;
  logic [RAND_W-1:0]   rnd0;
  logic [MAG_W-1:0]    s_sum;
  logic [MAG_W-1:0]    mag;
  logic [MAG_W-1:0]    k_full;
  logic                p_one;
  logic                p_zero;
  logic [EXP_IDX_W-1:0] k_idx;
  logic [PROB_W-1:0]   bank_q [EXP_BANKS];
  logic [EXP_SEL_W-1:0] bank_sel;
  logic [PROB_W-1:0]   prob;
  logic [PROB_W-1:0]   inc;
  logic [SUM_W-1:0]    rej_old;
  logic [SUM_W:0]      rej_add;
  logic                take;

  logic [POS_W-1:0]     pos_cell [MAX_CHAIN];
  logic [POS_W-1:0]     partner_cell [MAX_CHAIN];
  logic [MAX_CHAIN-1:0] match0, match1;
  logic [POS_W-1:0]     r0, r1;

  logic [COUNT_W-1:0] parity_cnt [2];
  logic               out_valid;

  // Pair sum and table index.
  assign s_sum  = {w0[WEIGHT_W-1], w0} + {ent_q[ENT_W-1], ent_q[ENT_W-1:RAND_W]};
  assign mag    = ~s_sum + MAG_W'(1);
  assign k_full = mag >> EXP_SHIFT;

  always_ff @(posedge clk) begin
    if (cmd.cap_w0) begin
      w0   <= ent_q[ENT_W-1:RAND_W];
      rnd0 <= ent_q[RAND_W-1:0];
    end
    if (cmd.cap_prob) begin
      p_one  <= !s_sum[MAG_W-1];
      p_zero <= (k_full >= MAG_W'(EXP_TABLE_DEPTH));
      k_idx  <= EXP_IDX_W'(k_full);
      for (int r = 0; r < MAX_CHAIN; r++) begin
        match0[r] <= (32'(r) < 32'(cmd.chain_len)) && (pos_cell[r] == cmd.pair);
        match1[r] <= (32'(r) < 32'(cmd.chain_len)) &&
                     (pos_cell[r] == cmd.pair + POS_W'(1));
      end
    end
    if (cmd.cap_look) begin
      for (int b = 0; b < EXP_BANKS; b++) begin
        bank_q[b] <= exp_rom[b][k_idx[EXP_BANK_W-1:0]];
      end
      bank_sel <= EXP_SEL_W'(k_idx >> EXP_BANK_W);
    end
  end

  always_comb begin
    r0 = '0;
    r1 = '0;
    for (int r = 0; r < MAX_CHAIN; r++) begin
      if (match0[r]) begin
        r0 = r0 | POS_W'(r);
      end
      if (match1[r]) begin
        r1 = r1 | POS_W'(r);
      end
    end
  end

  always_comb begin
    if (p_one) begin
      prob = PROB_ONE;
    end else if (p_zero) begin
      prob = '0;
    end else begin
      prob = bank_q[bank_sel];
    end
    inc     = PROB_ONE - prob;
    rej_old = rej_valid_q ? rej_q : '0;
    rej_add = {1'b0, rej_old} + (SUM_W+1)'(inc);
    rej_new = rej_add[SUM_W] ? SUM_MAX : rej_add[SUM_W-1:0];
    take    = ({1'b0, rnd0} < prob) && (|match0) && (|match1);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rej_valid <= '0;
    end else if (cmd.decide) begin
      rej_valid[cmd.pair] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.rej_rd) begin
      rej_valid_q <= (32'(cmd.rej_addr) < REJ_DEPTH) && rej_valid[REJ_AW'(cmd.rej_addr)];
    end
  end

  // Permutation cells, one per rank.
  always_ff @(posedge clk) begin
    if (rst || cmd.perm_init) begin
      for (int r = 0; r < MAX_CHAIN; r++) begin
        pos_cell[r]     <= POS_W'(r);
        partner_cell[r] <= POS_W'(r);
      end
    end else if (cmd.partner_init) begin
      for (int r = 0; r < MAX_CHAIN; r++) begin
        partner_cell[r] <= POS_W'(r);
      end
    end else if (cmd.decide && take) begin
      for (int r = 0; r < MAX_CHAIN; r++) begin
        if (match0[r]) begin
          pos_cell[r]     <= cmd.pair + POS_W'(1);
          partner_cell[r] <= r1;
        end else if (match1[r]) begin
          pos_cell[r]     <= cmd.pair;
          partner_cell[r] <= r0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      parity_cnt[0] <= '0;
      parity_cnt[1] <= '0;
    end else if (cmd.bump && (parity_cnt[cmd.parity] != COUNT_MAX)) begin
      parity_cnt[cmd.parity] <= parity_cnt[cmd.parity] + COUNT_W'(1);
    end
  end

  // Output register.
  assign stat.out_free = !out_valid || result.ready;
  assign result.valid  = out_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid <= 1'b1;
    end else if (result.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      result.rank_index         <= cmd.out_rank;
      result.new_position       <= pos_cell[cmd.out_rank];
      result.swap_mate          <= partner_cell[cmd.out_rank];
      result.pair_rejection_sum <= (cmd.out_last || !rej_valid_q) ? '0 : rej_q;
      result.parity_event_count <= parity_cnt[cmd.out_rank[0]];
      result.last_of_event      <= cmd.out_last;
    end
  end

endmodule

`default_nettype wire

[hdl/replica_exchange_swap.sv]
// Loading: one input transfer per cycle, one chain position each; results only after the last.
// Exchange pass: each tested pair steps through the states RD0, RD1, PROB, LOOK and DEC, then END
// closes the event; one table lookup and one pass over the rank cells per pair. Results then follow
// in rank order, each read in ORD and sent from OPUT whenever the output register is free.
// Reset (rst, synchronous): identity ranks, statistics and parity cleared, chain length 16.
`default_nettype none

module replica_exchange_swap import rxs_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             cfg_we,
  input  logic [CFG_W-1:0] cfg_data,
  rxs_sample_if.sink       sample,
  rxs_result_if.source     result
);

  // The controller sequences loading, the per-pair exchange test and the
  // per-rank output; the datapath owns all storage, the table and the
  // output register. They talk only through these two structs.
  rxs_cmd_t  cmd;
  rxs_stat_t stat;

  // Controller: holds the chain length, load index, current pair, output
  // rank counter and the phase of the next exchange event.
  rxs_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_data (cfg_data),
    .in_valid (sample.valid),
    .in_ready (sample.ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  // Datapath: sample memory, rejection sum memory, acceptance table,
  // the rank cells that hold positions and partners, the event counters
  // and the output register that decouples the result transfer.
  rxs_dp u_dp (
    .clk              (clk),
    .rst              (rst),
    .cmd              (cmd),
    .log_weight_ratio (sample.log_weight_ratio),
    .uniform_random   (sample.uniform_random),
    .stat             (stat),
    .result           (result)
  );

`ifndef SYNTHESIS
  // While results of an event are still being sent, no new sample is taken.
  a_no_load_midevent: assert property (@(posedge clk) disable iff (rst)
    result.valid && !result.last_of_event |-> !sample.ready)
    else $error("sample accepted while an event is still emitting results");

  // The swap decision always follows the table lookup, which follows the index stage.
  a_decide_order: assert property (@(posedge clk) disable iff (rst)
    cmd.decide |-> $past(cmd.cap_look) && $past(cmd.cap_prob, 2))
    else $error("swap decision out of pipeline order");

  // Input transfers only happen outside the exchange pass and output phase.
  a_load_exclusive: assert property (@(posedge clk) disable iff (rst)
    sample.valid && sample.ready |-> !cmd.decide && !cmd.out_load && !cmd.bump)
    else $error("input transfer during exchange pass");
`endif

endmodule

`default_nettype wire

[test/testbench.sv]
`default_nettype none

module testbench;
  import rxs_pkg::*;

  // Run limits. The watchdog limit lies far above what a correct run needs, even
  // with the longest idle bursts on both sides, so it has plenty of room.
  localparam int CYCLE_LIMIT   = 400000;
  localparam int SAMPLE_TARGET = 270;
  // Past this many samples both sides stop idling and run at full rate.
  localparam int CALM_FROM     = 225;

  // One expected or observed per-rank result of an exchange event.
  typedef struct packed {
    logic [POS_W-1:0]   rank_index;
    logic [POS_W-1:0]   new_position;
    logic [POS_W-1:0]   swap_mate;
    logic [SUM_W-1:0]   rej_sum;
    logic [COUNT_W-1:0] event_count;
    logic               last;
  } rank_report_t;

  // Mirrors the swap unit: it collects the loaded chain positions, runs the
  // exchange pass on the last one, and queues the per-rank reports that the
  // pass produces. Observed reports are checked in order against that queue.
  class exchange_tracker;
    int unsigned                chain_len;
    logic [POS_W-1:0]           pos_of_rank[MAX_CHAIN];
    logic [POS_W-1:0]           partner_of[MAX_CHAIN];
    bit                         odd_phase;
    logic signed [WEIGHT_W-1:0] weight_q[MAX_CHAIN];
    logic [RAND_W-1:0]          draw_q[MAX_CHAIN];
    logic [SUM_W-1:0]           rej_sum[MAX_CHAIN];
    logic [COUNT_W-1:0]         event_count[2];
    int unsigned                fill;
    logic [PROB_W-1:0]          exp_lut[EXP_TABLE_DEPTH];
    rank_report_t               awaited[$];
    int unsigned                mismatch_count;

    function new();
      longint unsigned kk, y, acc, term;
      // Acceptance table: e^-y by a six-term series in Q1.31, raised to the
      // 256th power by repeated rounded squaring, then cut to 17 bits.
      for (int k = 0; k < EXP_TABLE_DEPTH; k++) begin
        kk   = k;
        y    = (kk << 27) / EXP_TABLE_DEPTH;
        acc  = 64'd1 << 31;
        term = 64'd1 << 31;
        for (int n = 1; n <= 6; n++) begin
          term = ((term * y) >> 31) / n;
          if (n % 2 == 1) begin
            acc = acc - term;
          end else begin
            acc = acc + term;
          end
        end
        for (int n = 0; n < 8; n++) begin
          acc = (acc * acc + (64'd1 << 30)) >> 31;
        end
        exp_lut[k] = PROB_W'((acc + (64'd1 << 14)) >> 15);
      end
      chain_len = MAX_CHAIN;
      for (int r = 0; r < MAX_CHAIN; r++) begin
        pos_of_rank[r] = POS_W'(r);
        partner_of[r]  = POS_W'(r);
        weight_q[r]    = '0;
        draw_q[r]      = '0;
        rej_sum[r]     = '0;
      end
      odd_phase      = 1'b0;
      event_count[0] = '0;
      event_count[1] = '0;
      fill           = 0;
      mismatch_count = 0;
    endfunction

    // A length write clamps the value and restarts the ranks and the load;
    // statistics and the parity survive it.
    function void write_length(logic [CFG_W-1:0] raw);
      int unsigned v;
      v = raw;
      if (v < 2) begin
        v = 2;
      end
      if (v > MAX_CHAIN) begin
        v = MAX_CHAIN;
      end
      chain_len = v;
      for (int r = 0; r < MAX_CHAIN; r++) begin
        pos_of_rank[r] = POS_W'(r);
        partner_of[r]  = POS_W'(r);
      end
      fill = 0;
    endfunction

    function logic [PROB_W-1:0] swap_probability(int s);
      int unsigned m, k;
      if (s >= 0) begin
        return PROB_ONE;
      end
      m = -s;
      k = (m * EXP_TABLE_DEPTH) >> 12;
      if (k >= EXP_TABLE_DEPTH) begin
        return '0;
      end
      return exp_lut[k];
    endfunction

    function void absorb_sample(logic signed [WEIGHT_W-1:0] w, logic [RAND_W-1:0] u);
      int                 s;
      logic [PROB_W-1:0]  p;
      logic [SUM_W:0]     widened;
      int                 r0, r1;
      bit                 f0, f1;
      rank_report_t       rep;
      if (fill < MAX_CHAIN) begin
        weight_q[fill] = w;
        draw_q[fill]   = u;
      end
      fill++;
      if (fill < chain_len) begin
        return;
      end
      fill = 0;
      for (int r = 0; r < int'(chain_len); r++) begin
        partner_of[r] = POS_W'(r);
      end
      for (int i = int'(odd_phase); i + 1 < int'(chain_len); i += 2) begin
        s       = int'(weight_q[i]) + int'(weight_q[i+1]);
        p       = swap_probability(s);
        widened = {1'b0, rej_sum[i]} + (SUM_W + 1)'(PROB_ONE - p);
        rej_sum[i] = widened[SUM_W] ? SUM_MAX : widened[SUM_W-1:0];
        if ({1'b0, draw_q[i]} < p) begin
          f0 = 1'b0;
          f1 = 1'b0;
          r0 = 0;
          r1 = 0;
          for (int r = 0; r < int'(chain_len); r++) begin
            if (pos_of_rank[r] == POS_W'(i)) begin
              r0 = r;
              f0 = 1'b1;
            end else if (pos_of_rank[r] == POS_W'(i + 1)) begin
              r1 = r;
              f1 = 1'b1;
            end
          end
          if (f0 && f1) begin
            pos_of_rank[r0] = POS_W'(i + 1);
            pos_of_rank[r1] = POS_W'(i);
            partner_of[r0]  = POS_W'(r1);
            partner_of[r1]  = POS_W'(r0);
          end
        end
      end
      if (event_count[odd_phase] != COUNT_MAX) begin
        event_count[odd_phase] = event_count[odd_phase] + 1'b1;
      end
      odd_phase = ~odd_phase;
      for (int r = 0; r < int'(chain_len); r++) begin
        rep.rank_index   = POS_W'(r);
        rep.new_position = pos_of_rank[r];
        rep.swap_mate    = partner_of[r];
        rep.rej_sum      = (r + 1 < int'(chain_len)) ? rej_sum[r] : '0;
        rep.event_count  = event_count[r % 2];
        rep.last         = (r + 1 == int'(chain_len));
        awaited.push_back(rep);
      end
    endfunction

    function void match_field(string field, logic [63:0] want, logic [63:0] got);
      if (want !== got) begin
        $error("%s: expected %0h, got %0h", field, want, got);
        mismatch_count++;
      end
    endfunction

    function void check_report(rank_report_t got);
      rank_report_t want;
      if (awaited.size() == 0) begin
        $error("result for rank %0d arrived with nothing expected", got.rank_index);
        mismatch_count++;
        return;
      end
      want = awaited.pop_front();
      match_field("rank_index", 64'(want.rank_index), 64'(got.rank_index));
      match_field("new_position", 64'(want.new_position), 64'(got.new_position));
      match_field("swap_mate", 64'(want.swap_mate), 64'(got.swap_mate));
      match_field("pair_rejection_sum", 64'(want.rej_sum), 64'(got.rej_sum));
      match_field("parity_event_count", 64'(want.event_count), 64'(got.event_count));
      match_field("last_of_event", 64'(want.last), 64'(got.last));
    endfunction
  endclass

  logic             clk;
  logic             rst;
  logic             cfg_we;
  logic [CFG_W-1:0] cfg_data;

  rxs_sample_if sample ();
  rxs_result_if result ();

  exchange_tracker tracker;
  int              cycle_count = 0;
  int              samples_sent = 0;
  // Chance in percent that a transfer is preceded by an idle burst.
  int              gap_pct = 0;
  int              stall_pct = 0;

  replica_exchange_swap i_dut (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_data (cfg_data),
    .sample   (sample),
    .result   (result)
  );

  always begin
    clk = 1'b0;
    #10;
    clk = 1'b1;
    #10;
  end

  // Watchdog: a hung handshake or a lost result ends the run as a failure.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  // Both channels are observed at the rising edge. Inputs change only by
  // nonblocking assignment at that edge, so the values read here are the ones
  // the block saw when the transfer happened.
  always @(posedge clk) begin
    rank_report_t got;
    if (!rst && sample.valid && sample.ready) begin
      tracker.absorb_sample(sample.log_weight_ratio, sample.uniform_random);
    end
    if (!rst && result.valid && result.ready) begin
      got.rank_index   = result.rank_index;
      got.new_position = result.new_position;
      got.swap_mate    = result.swap_mate;
      got.rej_sum      = result.pair_rejection_sum;
      got.event_count  = result.parity_event_count;
      got.last         = result.last_of_event;
      tracker.check_report(got);
    end
  end

  // The result side drops ready in idle bursts. Each pass of
  // the loop makes exactly one assignment per clock edge.
  initial begin
    result.ready <= 1'b0;
    @(posedge clk);
    forever begin
      if ($urandom_range(99) < stall_pct) begin
        result.ready <= 1'b0;
        repeat ($urandom_range(1, 9)) @(posedge clk);
      end
      result.ready <= 1'b1;
      @(posedge clk);
    end
  end

  // Offers one chain position and returns at the edge where it is taken.
  // Valid is left high so that back-to-back samples follow without a gap.
  task automatic send_sample(input logic signed [WEIGHT_W-1:0] w,
                             input logic [RAND_W-1:0] u);
    if ($urandom_range(99) < gap_pct) begin
      sample.valid <= 1'b0;
      repeat ($urandom_range(1, 9)) @(posedge clk);
    end
    sample.valid            <= 1'b1;
    sample.log_weight_ratio <= w;
    sample.uniform_random   <= u;
    @(posedge clk);
    while (!sample.ready) @(posedge clk);
    samples_sent++;
  endtask

  // Length writes happen only with the block at rest: every expected result
  // has come back, and the task then idles so that a partial load is settled.
  // The first wait lets the monitor take in the sample of the last edge.
  task automatic set_length(input logic [CFG_W-1:0] raw);
    sample.valid <= 1'b0;
    @(posedge clk);
    while (tracker.awaited.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    cfg_we   <= 1'b1;
    cfg_data <= raw;
    @(posedge clk);
    cfg_we <= 1'b0;
    tracker.write_length(raw);
  endtask

  // Most weights fall where the sum of a pair lands inside the table range,
  // so the acceptance is a real fraction; the rest covers every bit pattern.
  function automatic logic signed [WEIGHT_W-1:0] rand_weight();
    case ($urandom_range(9)) inside
      0, 1:    return WEIGHT_W'($urandom);
      2: begin
        case ($urandom_range(3))
          0:       return 16'sh7FFF;
          1:       return 16'sh8000;
          2:       return 16'sh0000;
          default: return 16'shFFFF;
        endcase
      end
      default: return WEIGHT_W'(int'($urandom_range(0, 2900)) - 2300);
    endcase
  endfunction

  function automatic logic [RAND_W-1:0] rand_draw();
    case ($urandom_range(15))
      0:       return '0;
      1:       return '1;
      default: return RAND_W'($urandom);
    endcase
  endfunction

  function automatic int pick_idle_pct();
    case ($urandom_range(3))
      0:       return 0;
      1:       return 10;
      2:       return 30;
      default: return 60;
    endcase
  endfunction

  initial begin
    logic [CFG_W-1:0] raw_len;
    rst                     <= 1'b1;
    cfg_we                  <= 1'b0;
    cfg_data                <= '0;
    sample.valid            <= 1'b0;
    sample.log_weight_ratio <= '0;
    sample.uniform_random   <= '0;
    tracker = new();
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    gap_pct   = 30;
    stall_pct = 30;

    // Directed event at the reset length of sixteen, even pairs tested.
    // Both weights at the positive limit: acceptance is one, so even the
    // largest random fraction swaps.
    send_sample(16'sh7FFF, 16'hFFFF);
    send_sample(16'sh7FFF, 16'h5555);
    // Both at the negative limit: acceptance is zero, a zero draw keeps the pair.
    send_sample(16'sh8000, 16'h0000);
    send_sample(16'sh8000, 16'hAAAA);
    // A sum of exactly zero counts as certain acceptance.
    send_sample(16'sh0000, 16'h0000);
    send_sample(16'sh0000, 16'h1234);
    // The smallest negative sum maps to the first table entry, which is one.
    send_sample(16'shFFFF, 16'hFFFF);
    send_sample(16'sh0000, 16'hFEDC);
    // A sum of -16.0 is just past the table and gives zero.
    send_sample(-16'sd4096, 16'h0000);
    send_sample(16'sh0000, 16'h8000);
    // One step inside the table: the last entry, a tiny acceptance.
    send_sample(-16'sd4095, 16'h0003);
    send_sample(16'sh0000, 16'h7FFF);
    // A sum of -1.0 with the draw right at the edge of e^-1.
    send_sample(-16'sd256, 16'd24108);
    send_sample(16'sh0000, 16'h0F0F);
    // Limits of opposite sign sum to -1 LSB.
    send_sample(16'sh7FFF, 16'hF0F0);
    send_sample(16'sh8000, 16'h0001);

    // A zero length clamps to two. The parity is now odd, so this event
    // tests no pair at all; the next one tests the single pair.
    set_length('0);
    send_sample(16'sh0100, 16'h0000);
    send_sample(16'sh0100, 16'hFFFF);
    send_sample(-16'sd300, 16'h4000);
    send_sample(16'sh0000, 16'hC000);

    // All ones clamps to sixteen; a length write in the middle of a load
    // discards the positions loaded so far and restarts the ranks.
    set_length('1);
    send_sample(16'sh1000, 16'h2222);
    send_sample(-16'sd1000, 16'h3333);
    send_sample(16'sh0042, 16'h4444);
    set_length(CFG_W'(1));
    send_sample(rand_weight(), rand_draw());
    send_sample(rand_weight(), rand_draw());

    // Random phases: a length, one to four full events, and sometimes a
    // trailing partial load that the next length write cancels. Small chains
    // dominate since they give the most events per sample.
    while (samples_sent < SAMPLE_TARGET) begin
      if (samples_sent >= CALM_FROM) begin
        gap_pct   = 0;
        stall_pct = 0;
      end else begin
        gap_pct   = pick_idle_pct();
        stall_pct = pick_idle_pct();
      end
      case ($urandom_range(9)) inside
        0, 1, 2: raw_len = CFG_W'($urandom_range(0, 31));
        8, 9:    raw_len = CFG_W'($urandom_range(6, 16));
        default: raw_len = CFG_W'($urandom_range(2, 5));
      endcase
      set_length(raw_len);
      repeat ($urandom_range(1, 4)) begin
        repeat (tracker.chain_len) send_sample(rand_weight(), rand_draw());
      end
      if (samples_sent < CALM_FROM && $urandom_range(4) == 0) begin
        repeat ($urandom_range(1, tracker.chain_len - 1)) begin
          send_sample(rand_weight(), rand_draw());
        end
      end
    end
    sample.valid <= 1'b0;

    // Drain, then give the block time to show any stray result. The first
    // wait lets the monitor take in the final sample.
    @(posedge clk);
    while (tracker.awaited.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
    if (tracker.mismatch_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

`default_nettype wire
